// File: rtl/aarm_pkg.sv
// Shared types, constants and helper functions for the axis auto-range mapper.
// Used by the channel interfaces and by every module of the block.
package aarm_pkg;

	localparam int NUM_AXES    = 3;
	localparam int SAMPLE_BITS = 10;
	localparam int VAL_BITS    = 8;
	localparam int AXIS_BITS   = 2;
	localparam int CFG_IDX_W   = 4;
	localparam int AXIS_IDX_W  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int PROD_BITS   = SAMPLE_BITS + VAL_BITS;
	localparam int QCNT_W      = $clog2(VAL_BITS);
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

	localparam int FS_RESET      = 255;
	localparam int DLOW_RESET    = 108;
	localparam int DHIGH_RESET   = 148;
	localparam int DCENTER_RESET = 128;
	localparam int MIN0_RESET    = 50;
	localparam int MAX0_RESET    = 950;
	localparam int MINN_RESET    = 200;
	localparam int MAXN_RESET    = 800;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [VAL_BITS-1:0]    val_t;
	typedef logic [AXIS_BITS-1:0]   axis_t;
	typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;
	typedef logic [AXIS_IDX_W-1:0]  axis_idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_SCALE  = 4'd0,
		REG_DEAD_LOW    = 4'd1,
		REG_DEAD_HIGH   = 4'd2,
		REG_DEAD_CENTER = 4'd3
	} cfg_reg_t;

	typedef struct packed {
		val_t full_scale;
		val_t dead_low;
		val_t dead_high;
		val_t dead_center;
	} cfg_t;

	typedef struct packed {
		sample_t lo;
		sample_t hi;
	} travel_t;

	// Reset values that do not fit the sample width saturate to full scale.
	function automatic sample_t sat_sample(int unsigned v);
		return (v > SAMPLE_MAX) ? sample_t'(SAMPLE_MAX) : sample_t'(v);
	endfunction

	function automatic sample_t travel_min_reset(int unsigned axis);
		return sat_sample((axis == 0) ? MIN0_RESET : MINN_RESET);
	endfunction

	function automatic sample_t travel_max_reset(int unsigned axis);
		return sat_sample((axis == 0) ? MAX0_RESET : MAXN_RESET);
	endfunction

endpackage

// File: rtl/aarm_ifs.sv
// Valid/ready channel interfaces: sample input, mapped result output, register writes.
// Depends on aarm_pkg for the payload types.
interface aarm_in_if;
	import aarm_pkg::*;
	logic    valid;
	logic    ready;
	axis_t   axis_id;
	sample_t sample;
	modport source (output valid, output axis_id, output sample, input ready);
	modport sink (input valid, input axis_id, input sample, output ready);
endinterface

interface aarm_out_if;
	import aarm_pkg::*;
	logic  valid;
	logic  ready;
	axis_t axis_out;
	val_t  mapped_value;
	modport source (output valid, output axis_out, output mapped_value, input ready);
	modport sink (input valid, input axis_out, input mapped_value, output ready);
endinterface

interface aarm_cfg_if;
	import aarm_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	val_t     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/axis_autorange_map_deadzone.sv
// Top level of the auto-ranging joystick axis mapper with a central dead band.
// Depends on aarm_pkg, the channel interfaces, aarm_cfg_regs, aarm_travel, aarm_divider.
//
// Channel  | Direction | Payload                        | Handshake
// ---------+-----------+--------------------------------+-------------
// samples  | in        | axis_id[1:0], sample[9:0]      | valid/ready
// results  | out       | axis_out[1:0], mapped_value[7:0]| valid/ready
// cfg      | in        | index[3:0], data[7:0]          | valid/ready
//
// A request on a valid axis passes the travel update and operand step, the multiply
// step, the quotient steps of the shared one-bit-per-cycle divider, a step that
// takes the quotient and a finish step, then returns to the idle state that
// accepts the next request. A request on an axis number past the last axis
// goes from the idle state straight to the finish step.
// The result sits in an output register, so a new request is taken while an
// earlier result still waits; the finish step stalls only while that register is
// full and the sink is not ready. arst_n clears the control state, the registers and
// the travel store to their reset values at once; there is no clearing pass.
module axis_autorange_map_deadzone (
	input logic        clk,
	input logic        arst_n,
	aarm_in_if.sink    samples,
	aarm_out_if.source results,
	aarm_cfg_if.sink   cfg
);
	import aarm_pkg::*;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_UPDATE = 5'b00010,
		S_LAUNCH = 5'b00100,
		S_WAIT   = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t  state_q;
	axis_t   axis_q;
	sample_t sample_q;
	sample_t off_q;
	sample_t span_q;
	logic    nz_q;
	logic    bypass_q;
	val_t    raw_q;

	logic    out_valid_q;
	axis_t   out_axis_q;
	val_t    out_value_q;

	cfg_t    cfg_regs;
	travel_t trav;
	logic    div_done;
	val_t    div_quot;

	logic    accept;
	logic    axis_ok;
	sample_t span_c;
	sample_t off_c;
	logic    nz_c;
	logic    in_band;
	val_t    final_value;
	logic    out_free;
	logic    load_out;

	aarm_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	// The travel store is written once per request on a valid axis, in the update state.
	aarm_travel u_travel (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (state_q == S_UPDATE),
		.axis   (axis_q),
		.sample (sample_q),
		.trav   (trav)
	);

	aarm_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_LAUNCH),
		.scale  (cfg_regs.full_scale),
		.off    (off_q),
		.span   (span_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign samples.ready = (state_q == S_IDLE);
	assign accept        = samples.valid && samples.ready;
	assign axis_ok       = (int'(samples.axis_id) < NUM_AXES);

	// Offset and span from the freshly updated travel limits. The offset is
	// clamped to the span so the quotient never exceeds the full scale.
	always_comb begin
		span_c = trav.hi - trav.lo;
		off_c  = sample_q - trav.lo;
		nz_c   = (trav.hi > trav.lo) && (sample_q >= trav.lo);
		if (off_c > span_c) begin
			off_c = span_c;
		end
	end

	// Dead band substitution. An out-of-range axis reports zero untouched.
	always_comb begin
		in_band     = !bypass_q && (raw_q >= cfg_regs.dead_low) &&
		              (raw_q <= cfg_regs.dead_high);
		final_value = in_band ? cfg_regs.dead_center : raw_q;
	end

	assign out_free = !out_valid_q || results.ready;
	assign load_out = (state_q == S_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= axis_ok ? S_UPDATE : S_FINISH;
					end
				end
				S_UPDATE: state_q <= S_LAUNCH;
				S_LAUNCH: state_q <= S_WAIT;
				S_WAIT: begin
					if (div_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q   <= samples.axis_id;
			sample_q <= samples.sample;
			bypass_q <= !axis_ok;
			raw_q    <= '0;
		end
		if (state_q == S_UPDATE) begin
			off_q  <= off_c;
			span_q <= span_c;
			nz_q   <= nz_c;
		end
		if (state_q == S_WAIT && div_done) begin
			raw_q <= nz_q ? div_quot : '0;
		end
	end

	// Output register: holds a finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_axis_q  <= axis_q;
			out_value_q <= final_value;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.axis_out     = out_axis_q;
	assign results.mapped_value = out_value_q;

`ifndef SYNTH
	// The divider only finishes while the sequencer is waiting for it.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_WAIT)
		else $error("divider finished outside the wait state");

	// Travel limits keep a strictly positive span after every update.
	a_span_positive: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPDATE |-> trav.hi > trav.lo)
		else $error("travel maximum not above travel minimum");

	// The clamped offset keeps the quotient within the full scale.
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(div_done && nz_q) |-> div_quot <= cfg_regs.full_scale)
		else $error("quotient above full scale");

	// A finish step that loads the output register shows a result next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> results.valid && state_q == S_IDLE)
		else $error("loaded result not presented");
`endif

endmodule

// File: rtl/aarm_cfg_regs.sv
// Configuration register file: full scale and the three dead band settings.
// Depends on aarm_pkg and the aarm_cfg_if interface.
module aarm_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	aarm_cfg_if.sink      cfg,
	output aarm_pkg::cfg_t regs
);
	import aarm_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// Writes to indexes past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.full_scale  <= val_t'(FS_RESET);
			regs_q.dead_low    <= val_t'(DLOW_RESET);
			regs_q.dead_high   <= val_t'(DHIGH_RESET);
			regs_q.dead_center <= val_t'(DCENTER_RESET);
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_FULL_SCALE:  regs_q.full_scale  <= cfg.data;
				REG_DEAD_LOW:    regs_q.dead_low    <= cfg.data;
				REG_DEAD_HIGH:   regs_q.dead_high   <= cfg.data;
				REG_DEAD_CENTER: regs_q.dead_center <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/aarm_travel.sv
// Per-axis travel minimum and maximum store with its update rule.
// Depends on aarm_pkg.
module aarm_travel (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  aarm_pkg::axis_t   axis,
	input  aarm_pkg::sample_t sample,
	output aarm_pkg::travel_t trav
);
	import aarm_pkg::*;

	sample_t   min_q [NUM_AXES];
	sample_t   max_q [NUM_AXES];
	axis_idx_t idx;
	logic      sel_ok;
	sample_t   cur_lo;
	sample_t   cur_hi;

	assign idx    = axis[AXIS_IDX_W-1:0];
	assign sel_ok = (int'(idx) < NUM_AXES);

	always_comb begin
		cur_lo = sel_ok ? min_q[idx] : '0;
		cur_hi = sel_ok ? max_q[idx] : '0;
		// A new maximum takes precedence; the minimum moves only otherwise.
		trav.hi = (sample > cur_hi) ? sample : cur_hi;
		trav.lo = (sample <= cur_hi && sample < cur_lo) ? sample : cur_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				min_q[i] <= travel_min_reset(i);
				max_q[i] <= travel_max_reset(i);
			end
		end else if (upd && sel_ok) begin
			min_q[idx] <= trav.lo;
			max_q[idx] <= trav.hi;
		end
	end

endmodule

// File: rtl/aarm_divider.sv
// Shared scale-and-divide unit: one registered multiply, then a restoring
// divider that produces one quotient bit per cycle. Depends on aarm_pkg.
module aarm_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  aarm_pkg::val_t    scale,
	input  aarm_pkg::sample_t off,
	input  aarm_pkg::sample_t span,
	output logic              done,
	output aarm_pkg::val_t    quot
);
	import aarm_pkg::*;

	typedef enum logic [1:0] {
		D_IDLE = 2'b01,
		D_STEP = 2'b10
	} dstate_t;

	dstate_t                 state_q;
	logic [QCNT_W-1:0]       cnt_q;
	sample_t                 rem_q;
	val_t                    low_q;
	sample_t                 span_q;
	val_t                    quot_q;
	logic                    done_q;
	logic [PROD_BITS-1:0]    prod;
	logic [SAMPLE_BITS:0]    trial;
	logic [SAMPLE_BITS:0]    diff;
	logic                    ge;

	assign prod  = PROD_BITS'(scale) * PROD_BITS'(off);
	assign trial = {rem_q, low_q[VAL_BITS-1]};
	assign ge    = (trial >= {1'b0, span_q});
	assign diff  = trial - {1'b0, span_q};
	assign done  = done_q;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_STEP;
						cnt_q   <= '0;
					end
				end
				D_STEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == QCNT_W'(VAL_BITS - 1)) begin
						state_q <= D_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// The upper product bits start as the partial remainder; they stay below
	// the span because the quotient never exceeds the full scale.
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			rem_q  <= prod[PROD_BITS-1:VAL_BITS];
			low_q  <= prod[VAL_BITS-1:0];
			span_q <= span;
		end else if (state_q == D_STEP) begin
			rem_q  <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
			low_q  <= {low_q[VAL_BITS-2:0], 1'b0};
			quot_q <= {quot_q[VAL_BITS-2:0], ge};
		end
	end

endmodule
